FILE: rtl/core/pbe_pkg.sv
// ============================================================================
// pbe_pkg: shared types and constants of the piecewise Bezier evaluator
// Sizes of the segment table, fixed-point widths, opcode map of the shared
// multiplier and the control structures passed between the modules.
// ============================================================================
package pbe_pkg;

    localparam int MAX_SEGMENTS = 16;
    localparam int SEG_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int STORE_DEPTH  = MAX_SEGMENTS * 4;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);

    localparam int COORD_W = 24;
    localparam int TAN_W   = 28;
    localparam int T_W     = 18;
    localparam int LT_W    = 17;
    localparam logic [LT_W-1:0] T_ONE = LT_W'(65536);

    // Multiplier operand and accumulator widths.
    localparam int MA_W   = 35;
    localparam int MB_W   = 28;
    localparam int PROD_W = MA_W + MB_W;
    localparam int PACC_W = 74;
    localparam int TACC_W = 62;

    // Division by three: floor(n * DIV3_RECIP / 2^DIV3_SHIFT) is exact for n < 2^27.
    localparam logic [26:0] DIV3_RECIP = 27'd44739243;
    localparam int          DIV3_SHIFT = 27;

    // Item kinds and result status codes.
    localparam logic [1:0] KIND_CUBIC    = 2'd0;
    localparam logic [1:0] KIND_QUAD     = 2'd1;
    localparam int         KIND_EVAL_BIT = 1;

    localparam logic [1:0] STAT_EVAL   = 2'd0;
    localparam logic [1:0] STAT_EMPTY  = 2'd1;
    localparam logic [1:0] STAT_STORED = 2'd2;
    localparam logic [1:0] STAT_FULL   = 2'd3;

    // Opcodes of the shared multiplier; evaluation issues OP_UU to OP_TAN_LAST in order.
    localparam logic [5:0] OP_UU       = 6'd0;
    localparam logic [5:0] OP_TT       = 6'd1;
    localparam logic [5:0] OP_UT       = 6'd2;
    localparam logic [5:0] OP_UUU      = 6'd3;
    localparam logic [5:0] OP_UUT      = 6'd4;
    localparam logic [5:0] OP_UTT      = 6'd5;
    localparam logic [5:0] OP_TTT      = 6'd6;
    localparam logic [5:0] OP_POS_BASE = 6'd7;
    localparam logic [5:0] OP_POS_LAST = 6'd22;
    localparam logic [5:0] OP_TAN_BASE = 6'd23;
    localparam logic [5:0] OP_TAN_LAST = 6'd28;
    localparam logic [5:0] OP_QD_BASE  = 6'd29;
    localparam logic [5:0] OP_QD_LAST  = 6'd32;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    typedef struct packed {
        logic       clear;
        logic       issue;
        logic [5:0] op;
    } dp_ctrl_t;

    typedef struct packed {
        logic             rd;
        logic             wr;
        logic             inc;
        logic [1:0]       idx;
        logic [SEG_W-1:0] seg;
    } st_ctrl_t;

endpackage

FILE: rtl/core/pbe_store.sv
// ============================================================================
// pbe_store: segment point memory and segment counter
// One synchronous memory of four points per segment with a registered read,
// and the count of stored segments that selects the next free row.
// ============================================================================
module pbe_store (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pbe_pkg::st_ctrl_t           ctrl,
    input  pbe_pkg::point_t             wdata,
    output pbe_pkg::point_t             rdata,
    output logic [pbe_pkg::CNT_W-1:0]   count,
    output logic                        full
);
    import pbe_pkg::*;

    point_t             mem [STORE_DEPTH];
    point_t             rdata_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [ADDR_W-1:0]  waddr;
    logic [ADDR_W-1:0]  raddr;

    // Writes only happen during a load and reads only during an evaluation,
    // so the two ports never touch the same entry in one cycle.
    assign waddr = ADDR_W'({cnt_reg[SEG_W-1:0], ctrl.idx});
    assign raddr = ADDR_W'({ctrl.seg, ctrl.idx});

    always_ff @(posedge aclk) begin
        if (ctrl.wr) begin
            mem[waddr] <= wdata;
        end
        if (ctrl.rd) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign cnt_next = ctrl.inc ? cnt_reg + CNT_W'(1) : cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign rdata = rdata_reg;
    assign count = cnt_reg;
    assign full  = (cnt_reg >= CNT_W'(MAX_SEGMENTS));

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_SEGMENTS))
        else $error("segment count above table size");

    a_port_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.wr || ctrl.inc) |-> (!full && !ctrl.rd))
        else $error("write into a full table or during a read");

endmodule

FILE: rtl/core/pbe_datapath.sv
// ============================================================================
// pbe_datapath: shared multiplier with weight and sum registers
// One registered 35x28 multiplier works through Bernstein weights, position
// and tangent products and the quadratic raise, one product per cycle.
// ============================================================================
module pbe_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  pbe_pkg::dp_ctrl_t                    ctrl,
    input  logic [pbe_pkg::LT_W-1:0]             u,
    input  logic [pbe_pkg::LT_W-1:0]             lt,
    input  pbe_pkg::point_t [3:0]                ev_pts,
    input  pbe_pkg::point_t [3:0]                ld_pts,
    output logic signed [pbe_pkg::COORD_W-1:0]   pos_x,
    output logic signed [pbe_pkg::COORD_W-1:0]   pos_y,
    output logic signed [pbe_pkg::TAN_W-1:0]     tan_x,
    output logic signed [pbe_pkg::TAN_W-1:0]     tan_y,
    output pbe_pkg::point_t                      c1,
    output pbe_pkg::point_t                      c2
);
    import pbe_pkg::*;

    localparam logic signed [PACC_W-1:0] POS_HALF = PACC_W'(1) <<< 47;
    localparam logic signed [TACC_W-1:0] TAN_HALF = TACC_W'(1) <<< 31;
    localparam logic signed [27:0]       QD_BIAS  = 28'sd50331649;

    logic [32:0]                uu_reg, tt_reg, ut_reg;
    logic [48:0]                uuu_reg, uut_reg, utt_reg, ttt_reg;
    logic [48:0]                wgt [4];
    logic [33:0]                vw  [3];
    logic signed [MA_W-1:0]     ma;
    logic signed [MB_W-1:0]     mb;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [5:0]                 tag_reg;
    logic                       pv_reg;
    logic signed [PACC_W-1:0]   pacc_x_reg, pacc_y_reg, pterm, psum_x, psum_y;
    logic signed [TACC_W-1:0]   tacc_x_reg, tacc_y_reg, tterm, tsum_x, tsum_y;
    logic signed [COORD_W-1:0]  qd_reg [4];
    logic [3:0]                 pidx, ptag;
    logic [2:0]                 tidx, ttag;
    logic [1:0]                 qidx, qtag;
    logic [48:0]                wsel;
    logic signed [24:0]         dlt;
    logic signed [27:0]         qn;
    logic signed [COORD_W-1:0]  qa, qq;

    function automatic logic signed [COORD_W-1:0] coord(input point_t p, input logic c);
        coord = c ? p.y : p.x;
    endfunction

    always_comb begin
        wgt[0] = uuu_reg;
        wgt[1] = 49'({uut_reg, 1'b0} + {1'b0, uut_reg});
        wgt[2] = 49'({utt_reg, 1'b0} + {1'b0, utt_reg});
        wgt[3] = ttt_reg;
        vw[0]  = 34'({uu_reg, 1'b0} + {1'b0, uu_reg});
        vw[1]  = 34'({ut_reg, 2'b0} + {1'b0, ut_reg, 1'b0});
        vw[2]  = 34'({tt_reg, 1'b0} + {1'b0, tt_reg});
    end

    // Operand selection for the issued opcode.
    always_comb begin
        pidx = 4'(ctrl.op - OP_POS_BASE);
        tidx = 3'(ctrl.op - OP_TAN_BASE);
        qidx = 2'(ctrl.op - OP_QD_BASE);
        wsel = wgt[pidx[3:2]];
        dlt  = 25'(coord(ev_pts[tidx[2:1] + 2'd1], tidx[0]))
             - 25'(coord(ev_pts[tidx[2:1]], tidx[0]));
        qa   = coord(qidx[1] ? ld_pts[2] : ld_pts[0], qidx[0]);
        qq   = coord(ld_pts[1], qidx[0]);
        qn   = 28'(qa) + (28'(qq) <<< 1) + QD_BIAS;
        ma   = '0;
        mb   = '0;
        case (ctrl.op) inside
            OP_UU:  begin ma = MA_W'(u);       mb = MB_W'(u);  end
            OP_TT:  begin ma = MA_W'(lt);      mb = MB_W'(lt); end
            OP_UT:  begin ma = MA_W'(u);       mb = MB_W'(lt); end
            OP_UUU: begin ma = MA_W'(uu_reg);  mb = MB_W'(u);  end
            OP_UUT: begin ma = MA_W'(uu_reg);  mb = MB_W'(lt); end
            OP_UTT: begin ma = MA_W'(tt_reg);  mb = MB_W'(u);  end
            OP_TTT: begin ma = MA_W'(tt_reg);  mb = MB_W'(lt); end
            [OP_POS_BASE:OP_POS_LAST]: begin
                // The 49-bit weight is split in a low 25-bit and a high 24-bit half.
                ma = pidx[0] ? MA_W'(wsel[48:25]) : MA_W'(wsel[24:0]);
                mb = MB_W'(coord(ev_pts[pidx[3:2]], pidx[1]));
            end
            [OP_TAN_BASE:OP_TAN_LAST]: begin
                ma = MA_W'(vw[tidx[2:1]]);
                mb = MB_W'(dlt);
            end
            [OP_QD_BASE:OP_QD_LAST]: begin
                ma = MA_W'(DIV3_RECIP);
                mb = MB_W'({1'b0, qn[26:0]});
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= ma * mb;
        tag_reg  <= ctrl.op;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else begin
            pv_reg <= ctrl.issue;
        end
    end

    always_comb begin
        ptag  = 4'(tag_reg - OP_POS_BASE);
        ttag  = 3'(tag_reg - OP_TAN_BASE);
        qtag  = 2'(tag_reg - OP_QD_BASE);
        pterm = ptag[0] ? (PACC_W'(prod_reg) <<< 25) : PACC_W'(prod_reg);
        tterm = TACC_W'(prod_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            pacc_x_reg <= '0;
            pacc_y_reg <= '0;
            tacc_x_reg <= '0;
            tacc_y_reg <= '0;
        end else if (pv_reg) begin
            case (tag_reg) inside
                OP_UU:  uu_reg  <= prod_reg[32:0];
                OP_TT:  tt_reg  <= prod_reg[32:0];
                OP_UT:  ut_reg  <= prod_reg[32:0];
                OP_UUU: uuu_reg <= prod_reg[48:0];
                OP_UUT: uut_reg <= prod_reg[48:0];
                OP_UTT: utt_reg <= prod_reg[48:0];
                OP_TTT: ttt_reg <= prod_reg[48:0];
                [OP_POS_BASE:OP_POS_LAST]: begin
                    if (ptag[1]) begin
                        pacc_y_reg <= pacc_y_reg + pterm;
                    end else begin
                        pacc_x_reg <= pacc_x_reg + pterm;
                    end
                end
                [OP_TAN_BASE:OP_TAN_LAST]: begin
                    if (ttag[0]) begin
                        tacc_y_reg <= tacc_y_reg + tterm;
                    end else begin
                        tacc_x_reg <= tacc_x_reg + tterm;
                    end
                end
                [OP_QD_BASE:OP_QD_LAST]: begin
                    // The 3*2^24 part of the bias only touches bits above the kept field; the +1 rounds to nearest.
                    qd_reg[qtag] <= prod_reg[DIV3_SHIFT+COORD_W-1:DIV3_SHIFT];
                end
                default: ;
            endcase
        end
    end

    // Single rounding to nearest, ties upwards.
    assign psum_x = pacc_x_reg + POS_HALF;
    assign psum_y = pacc_y_reg + POS_HALF;
    assign tsum_x = tacc_x_reg + TAN_HALF;
    assign tsum_y = tacc_y_reg + TAN_HALF;
    assign pos_x  = psum_x[48+COORD_W-1:48];
    assign pos_y  = psum_y[48+COORD_W-1:48];
    assign tan_x  = tsum_x[32+TAN_W-1:32];
    assign tan_y  = tsum_y[32+TAN_W-1:32];
    assign c1     = '{y: qd_reg[1], x: qd_reg[0]};
    assign c2     = '{y: qd_reg[3], x: qd_reg[2]};

endmodule

FILE: rtl/core/piecewise_bezier_evaluator.sv
// ============================================================================
// piecewise_bezier_evaluator: table of cubic Bezier segments with evaluation
// Appends cubic or raised quadratic segments to a point memory and evaluates
// position and local tangent of the path at a global parameter.
// ============================================================================
//
//  channel   direction  handshake         word
//  s_        in         s_valid/s_ready   kind, four points, t_position
//  m_        out        m_valid/m_ready   pos_x/y, tan_x/y, status
//
// An evaluation first picks the segment and local t, then runs 29 products
// through the one shared 35x28 multiplier (weights, position halves, tangent
// terms) and rounding. A load runs four divisions by three for a quadratic
// on the same multiplier, then four writes through the single memory write
// port.
// Evaluations on an empty table and loads into a full table answer at once.
// Reset clears the count and control state; the point memory needs no clearing.
// A stalled result holds the block in its final step until the word is taken.
//
module piecewise_bezier_evaluator (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_kind,
    input  logic signed [pbe_pkg::COORD_W-1:0]   s_first_x,
    input  logic signed [pbe_pkg::COORD_W-1:0]   s_first_y,
    input  logic signed [pbe_pkg::COORD_W-1:0]   s_second_x,
    input  logic signed [pbe_pkg::COORD_W-1:0]   s_second_y,
    input  logic signed [pbe_pkg::COORD_W-1:0]   s_third_x,
    input  logic signed [pbe_pkg::COORD_W-1:0]   s_third_y,
    input  logic signed [pbe_pkg::COORD_W-1:0]   s_fourth_x,
    input  logic signed [pbe_pkg::COORD_W-1:0]   s_fourth_y,
    input  logic signed [pbe_pkg::T_W-1:0]       s_t_position,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [pbe_pkg::COORD_W-1:0]   m_pos_x,
    output logic signed [pbe_pkg::COORD_W-1:0]   m_pos_y,
    output logic signed [pbe_pkg::TAN_W-1:0]     m_tan_x,
    output logic signed [pbe_pkg::TAN_W-1:0]     m_tan_y,
    output logic [1:0]                           m_status
);
    import pbe_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    localparam logic [4:0] EVAL_READS    = 5'd4;
    localparam logic [4:0] EVAL_LAST_OP  = 5'(OP_TAN_LAST);
    localparam logic [4:0] EVAL_DONE     = 5'(OP_TAN_LAST) + 5'd2;
    localparam logic [4:0] LOAD_WR_FIRST = 5'd4;
    localparam logic [4:0] LOAD_DONE     = 5'd8;
    localparam logic signed [TAN_W-1:0] TAN_ONE = TAN_W'(256);
    localparam int SC_W = LT_W + CNT_W;

    logic [1:0]                 state_reg, state_next;
    logic [4:0]                 step_reg, step_next;
    logic [1:0]                 kind_reg;
    point_t [3:0]               ld_pts_reg;
    point_t [3:0]               ev_pts_reg;
    logic signed [T_W-1:0]      t_reg;
    logic [SEG_W-1:0]           seg_reg;
    logic [LT_W-1:0]            lt_reg, u_reg;
    logic                       m_valid_reg;
    logic signed [COORD_W-1:0]  m_pos_x_reg, m_pos_y_reg;
    logic signed [TAN_W-1:0]    m_tan_x_reg, m_tan_y_reg;
    logic [1:0]                 m_status_reg;

    logic                       accept, out_free, produce, ld_quad;
    logic signed [COORD_W-1:0]  res_pos_x, res_pos_y;
    logic signed [TAN_W-1:0]    res_tan_x, res_tan_y;
    logic [1:0]                 res_status;
    logic [LT_W-1:0]            t_clamp, lt_calc;
    logic [SC_W-1:0]            scaled, lt_raw;
    logic [CNT_W:0]             seg_raw, seg_cl, cnt_m1;
    dp_ctrl_t                   dp_ctrl;
    st_ctrl_t                   st_ctrl;
    point_t                     wdata, rdata, c1, c2;
    logic [CNT_W-1:0]           count;
    logic                       full;
    logic signed [COORD_W-1:0]  dp_pos_x, dp_pos_y;
    logic signed [TAN_W-1:0]    dp_tan_x, dp_tan_y;

    // A new word is taken only in idle and only if the output register can be
    // freed, so a result that answers at once never overwrites a waiting one.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign ld_quad  = (kind_reg == KIND_QUAD);

    // Segment selection: clamp t, scale by the count and split into segment
    // and local t. The top end of t lands in the last segment at local t one.
    always_comb begin
        if (t_reg[T_W-1]) begin
            t_clamp = '0;
        end else if (t_reg > T_W'(T_ONE)) begin
            t_clamp = T_ONE;
        end else begin
            t_clamp = t_reg[LT_W-1:0];
        end
        scaled  = SC_W'(t_clamp) * SC_W'(count);
        seg_raw = scaled[SC_W-1:16];
        cnt_m1  = (CNT_W+1)'(count) - (CNT_W+1)'(1);
        seg_cl  = (seg_raw > cnt_m1) ? cnt_m1 : seg_raw;
        lt_raw  = scaled - (SC_W'(seg_cl) << 16);
        lt_calc = (lt_raw > SC_W'(T_ONE)) ? T_ONE : lt_raw[LT_W-1:0];
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        produce    = 1'b0;
        res_pos_x  = '0;
        res_pos_y  = '0;
        res_tan_x  = '0;
        res_tan_y  = '0;
        res_status = STAT_EVAL;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    step_next = '0;
                    if (s_kind[KIND_EVAL_BIT]) begin
                        if (count == '0) begin
                            produce    = 1'b1;
                            res_tan_x  = TAN_ONE;
                            res_status = STAT_EMPTY;
                        end else begin
                            state_next = ST_PREP;
                        end
                    end else if (full) begin
                        produce    = 1'b1;
                        res_status = STAT_FULL;
                    end else begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_PREP: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (step_reg == EVAL_DONE) begin
                    if (out_free) begin
                        produce    = 1'b1;
                        res_pos_x  = dp_pos_x;
                        res_pos_y  = dp_pos_y;
                        res_tan_x  = dp_tan_x;
                        res_tan_y  = dp_tan_y;
                        res_status = STAT_EVAL;
                        state_next = ST_IDLE;
                    end
                end else begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_LOAD: begin
                if (step_reg == LOAD_DONE) begin
                    if (out_free) begin
                        produce    = 1'b1;
                        res_status = STAT_STORED;
                        state_next = ST_IDLE;
                    end
                end else begin
                    step_next = step_reg + 5'd1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Evaluation issues one multiplier opcode per step in opcode order up to OP_TAN_LAST;
    // a quadratic load issues its four divisions in the first load steps.
    always_comb begin
        dp_ctrl.clear = accept;
        dp_ctrl.issue = ((state_reg == ST_EVAL) && (step_reg <= EVAL_LAST_OP))
                     || ((state_reg == ST_LOAD) && ld_quad && (step_reg < LOAD_WR_FIRST));
        dp_ctrl.op    = (state_reg == ST_EVAL) ? OP_UU + 6'(step_reg)
                                               : OP_QD_BASE + 6'(step_reg);
        st_ctrl.rd    = (state_reg == ST_EVAL) && (step_reg < EVAL_READS);
        st_ctrl.wr    = (state_reg == ST_LOAD) && (step_reg >= LOAD_WR_FIRST)
                     && (step_reg < LOAD_DONE);
        st_ctrl.inc   = (state_reg == ST_LOAD) && (step_reg == LOAD_DONE) && out_free;
        st_ctrl.idx   = step_reg[1:0];
        st_ctrl.seg   = seg_reg;
    end

    // A raised quadratic stores start, both computed controls and its end.
    always_comb begin
        case (step_reg[1:0])
            2'd0:    wdata = ld_pts_reg[0];
            2'd1:    wdata = ld_quad ? c1 : ld_pts_reg[1];
            2'd2:    wdata = ld_quad ? c2 : ld_pts_reg[2];
            default: wdata = ld_quad ? ld_pts_reg[2] : ld_pts_reg[3];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            if (produce) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg      <= s_kind;
            ld_pts_reg[0] <= '{y: s_first_y,  x: s_first_x};
            ld_pts_reg[1] <= '{y: s_second_y, x: s_second_x};
            ld_pts_reg[2] <= '{y: s_third_y,  x: s_third_x};
            ld_pts_reg[3] <= '{y: s_fourth_y, x: s_fourth_x};
            t_reg         <= s_t_position;
        end
        if (state_reg == ST_PREP) begin
            seg_reg <= seg_cl[SEG_W-1:0];
            lt_reg  <= lt_calc;
            u_reg   <= T_ONE - lt_calc;
        end
        // Read data arrives in the step after its address.
        if ((state_reg == ST_EVAL) && (step_reg >= 5'd1) && (step_reg <= EVAL_READS)) begin
            ev_pts_reg[2'(step_reg - 5'd1)] <= rdata;
        end
        if (produce) begin
            m_pos_x_reg  <= res_pos_x;
            m_pos_y_reg  <= res_pos_y;
            m_tan_x_reg  <= res_tan_x;
            m_tan_y_reg  <= res_tan_y;
            m_status_reg <= res_status;
        end
    end

    pbe_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (st_ctrl),
        .wdata   (wdata),
        .rdata   (rdata),
        .count   (count),
        .full    (full)
    );

    pbe_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (dp_ctrl),
        .u       (u_reg),
        .lt      (lt_reg),
        .ev_pts  (ev_pts_reg),
        .ld_pts  (ld_pts_reg),
        .pos_x   (dp_pos_x),
        .pos_y   (dp_pos_y),
        .tan_x   (dp_tan_x),
        .tan_y   (dp_tan_y),
        .c1      (c1),
        .c2      (c2)
    );

    assign m_valid  = m_valid_reg;
    assign m_pos_x  = m_pos_x_reg;
    assign m_pos_y  = m_pos_y_reg;
    assign m_tan_x  = m_tan_x_reg;
    assign m_tan_y  = m_tan_y_reg;
    assign m_status = m_status_reg;

    a_count_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (count != $past(count)) |-> ($past(state_reg) == ST_LOAD))
        else $error("segment count changed outside a load");

    a_eval_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL) |-> (step_reg <= EVAL_DONE))
        else $error("evaluation step out of range");

    a_result_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (produce && m_valid_reg) |-> m_ready)
        else $error("result overwrites a word not yet taken");

endmodule
